// ----- rtl/c_escape_sequence_decoder_assert.svh -----
// Assertion macros for the C escape sequence decoder checker.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef C_ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define C_ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CED_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ced check failed");

// Next-cycle implication, checked outside reset.
`define CED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ced check failed");

`endif

// ----- rtl/ced_pkg.sv -----
// Shared types and status codes for the C escape sequence decoder.
// No dependencies; every other file but the assertion header imports this package.
`default_nettype none

package ced_pkg;

    // Status codes carried with each decoded word.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_NO_HEX  = 2'd2;
    localparam logic [1:0] ST_STRAY   = 2'd3;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       literal_end;
    } src_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       literal_done;
        logic       run_last;
    } dst_word_t;

    // All words caused by one input byte: one or two.
    typedef struct packed {
        logic      two;
        dst_word_t second;
        dst_word_t first;
    } run_t;

endpackage

`default_nettype wire

// ----- rtl/ced_front.sv -----
// Front end: accepts source bytes, tracks the escape state and builds
// the run of one or two decoded words for each byte that yields output. Depends on ced_pkg.
`default_nettype none

module ced_front
    import ced_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  src_word_t src_word,
    output logic      run_valid,
    output run_t      run,
    input  logic      run_ready
);

    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;
    localparam logic [1:0] MODE_OCT  = 2'd3;

    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_X         = 8'h78;

    function automatic dst_word_t make_word(input logic [7:0] data, input logic valid,
                                            input logic [1:0] status);
        dst_word_t w;
        w.out_byte     = valid ? data : 8'd0;
        w.byte_valid   = valid;
        w.status       = status;
        w.literal_done = 1'b0;
        w.run_last     = 1'b0;
        return w;
    endfunction

    // Returns {hit, value} for the simple escapes.
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h6e:   r = {1'b1, 8'd10};
            8'h74:   r = {1'b1, 8'd9};
            8'h72:   r = {1'b1, 8'd13};
            8'h61:   r = {1'b1, 8'd7};
            8'h62:   r = {1'b1, 8'd8};
            8'h66:   r = {1'b1, 8'd12};
            8'h76:   r = {1'b1, 8'd11};
            8'h5c, 8'h27, 8'h22, 8'h3f: r = {1'b1, c};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Returns {hit, value} for a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        logic [7:0] t;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            t = {5'd0, c[2:0]} + 8'd9;
            r = {1'b1, t[3:0]};
        end
        return r;
    endfunction

    logic [1:0] mode_reg, mode_next;
    logic [7:0] val_reg, val_next;
    logic [1:0] cnt_reg, cnt_next;

    logic [7:0] b;
    logic       last;
    logic       is_oct;
    logic [4:0] hex;
    logic [8:0] simple;
    logic       accept;
    dst_word_t  res [2];
    logic [1:0] n;

    assign b      = src_word.source_byte;
    assign last   = src_word.literal_end;
    assign is_oct = b inside {[8'h30:8'h37]};
    assign hex    = hex_digit(b);
    assign simple = simple_escape(b);

    assign src_ready = run_ready;
    assign accept    = src_valid && run_ready;

    always_comb
    begin
        mode_next = mode_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        res[0]    = make_word(8'd0, 1'b0, ST_OK);
        res[1]    = make_word(8'd0, 1'b0, ST_OK);
        n         = 2'd0;

        case (mode_reg)
            MODE_TEXT:
            begin
                if (b == CH_BACKSLASH) begin
                    mode_next = MODE_ESC;
                end else begin
                    res[n[0]] = make_word(b, 1'b1, ST_OK);
                    n = n + 2'd1;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_TEXT;
                if (b == CH_X) begin
                    mode_next = MODE_HEX;
                    val_next  = 8'd0;
                    cnt_next  = 2'd0;
                end else if (b == CH_NEWLINE) begin
                    // Line continuation: nothing comes out.
                end else if (simple[8]) begin
                    res[n[0]] = make_word(simple[7:0], 1'b1, ST_OK);
                    n = n + 2'd1;
                end else if (is_oct) begin
                    mode_next = MODE_OCT;
                    val_next  = {5'd0, b[2:0]};
                    cnt_next  = 2'd1;
                end else begin
                    res[n[0]] = make_word(b, 1'b1, ST_UNKNOWN);
                    n = n + 2'd1;
                end
            end
            MODE_HEX:
            begin
                if (hex[4]) begin
                    val_next = {val_reg[3:0], hex[3:0]};
                    if (cnt_reg != 2'd3) begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end else begin
                    res[n[0]] = make_word(val_reg, 1'b1,
                                          (cnt_reg == 2'd0) ? ST_NO_HEX : ST_OK);
                    n = n + 2'd1;
                    mode_next = MODE_TEXT;
                    if (b == CH_BACKSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        res[n[0]] = make_word(b, 1'b1, ST_OK);
                        n = n + 2'd1;
                    end
                end
            end
            default:
            begin
                if (is_oct && cnt_reg != 2'd3) begin
                    val_next = {val_reg[4:0], b[2:0]};
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2) begin
                        res[n[0]] = make_word(val_next, 1'b1, ST_OK);
                        n = n + 2'd1;
                        mode_next = MODE_TEXT;
                    end
                end else begin
                    res[n[0]] = make_word(val_reg, 1'b1, ST_OK);
                    n = n + 2'd1;
                    mode_next = MODE_TEXT;
                    if (b == CH_BACKSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        res[n[0]] = make_word(b, 1'b1, ST_OK);
                        n = n + 2'd1;
                    end
                end
            end
        endcase

        if (last) begin
            // Flush whatever escape is still open.
            if (mode_next == MODE_ESC) begin
                res[n[0]] = make_word(8'd0, 1'b0, ST_STRAY);
                n = n + 2'd1;
            end else if (mode_next == MODE_HEX) begin
                res[n[0]] = make_word(val_next, 1'b1,
                                      (cnt_next == 2'd0) ? ST_NO_HEX : ST_OK);
                n = n + 2'd1;
            end else if (mode_next == MODE_OCT) begin
                res[n[0]] = make_word(val_next, 1'b1, ST_OK);
                n = n + 2'd1;
            end
            if (n == 2'd0) begin
                res[0] = make_word(8'd0, 1'b0, ST_OK);
                n = 2'd1;
            end
            res[n[1]].literal_done = 1'b1;
            mode_next = MODE_TEXT;
            val_next  = 8'd0;
            cnt_next  = 2'd0;
        end

        if (n != 2'd0) begin
            res[n[1]].run_last = 1'b1;
        end
    end

    assign run_valid  = accept && (n != 2'd0);
    assign run.two    = n[1];
    assign run.first  = res[0];
    assign run.second = res[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_TEXT;
            val_reg  <= 8'd0;
            cnt_reg  <= 2'd0;
        end else if (accept) begin
            mode_reg <= mode_next;
            val_reg  <= val_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ced_queue.sv -----
// Two-entry queue of decoded runs between the front and back ends.
// Depends on ced_pkg for the run type.
`default_nettype none

module ced_queue
    import ced_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  run_t push_run,
    output logic full,
    input  logic pop,
    output run_t head,
    output logic head_valid
);

    run_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ced_back.sv -----
// Back end: takes runs from the queue and sends their words one per cycle,
// while dst is ready, through the output register. Depends on ced_pkg.
`default_nettype none

module ced_back
    import ced_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  run_t      head,
    input  logic      head_valid,
    output logic      pop,
    output logic      dst_valid,
    input  logic      dst_ready,
    output dst_word_t dst_word
);

    logic      sel_reg, sel_next;
    logic      valid_reg, valid_next;
    dst_word_t word_reg, word_next;
    logic      load;

    assign load = head_valid && (!valid_reg || dst_ready);

    always_comb
    begin
        pop        = load && (sel_reg || !head.two);
        sel_next   = sel_reg;
        valid_next = valid_reg;
        word_next  = word_reg;
        if (load) begin
            word_next  = sel_reg ? head.second : head.first;
            valid_next = 1'b1;
            sel_next   = !pop;
        end else if (dst_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign dst_valid = valid_reg;
    assign dst_word  = word_reg;

endmodule

`default_nettype wire

// ----- rtl/c_escape_sequence_decoder.sv -----
// Top level of the C string literal escape decoder.
// Depends on ced_pkg, ced_front, ced_queue and ced_back.
//
//  Channel   Dir   Word type    Contents
//  src       in    src_word_t   raw literal byte and end-of-literal flag
//  dst       out   dst_word_t   decoded byte, status and run markers
//
// The block takes one source word per cycle while the queue has room. A byte
// that yields two decoded words (an escape closed by the next character, or
// closed at literal end) keeps the back end busy with two words; the two-run
// queue absorbs that, so the input stalls only when the queue fills.
// A word goes through a queue slot and then the output register to reach dst.
// Reset is asynchronous and active low and returns the decoder to text mode.
// Either side may stall for any time; nothing is dropped or repeated.
`default_nettype none

module c_escape_sequence_decoder
    import ced_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  src_word_t src_word,
    output logic      dst_valid,
    input  logic      dst_ready,
    output dst_word_t dst_word
);

    // Front end to queue.
    logic run_valid;
    run_t run;
    logic q_full;

    // Queue to back end.
    run_t head;
    logic head_valid;
    logic pop;

    // The front end keeps the escape state and builds one run per byte that yields words.
    ced_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_word  (src_word),
        .run_valid (run_valid),
        .run       (run),
        .run_ready (!q_full)
    );

    // The queue decouples decoding from delivery.
    ced_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (run_valid),
        .push_run   (run),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // The back end splits each run into single words on dst.
    ced_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .dst_valid  (dst_valid),
        .dst_ready  (dst_ready),
        .dst_word   (dst_word)
    );

endmodule

`default_nettype wire

// ----- rtl/ced_checker.sv -----
// Port-level checker for the C escape sequence decoder, bound to the top.
// Depends on ced_pkg and c_escape_sequence_decoder_assert.svh.
`default_nettype none

`include "c_escape_sequence_decoder_assert.svh"

module ced_checker
    import ced_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      dst_valid,
    input wire logic      dst_ready,
    input wire dst_word_t dst_word
);

    // A stalled output word stays presented and unchanged.
    `CED_ASSERT_NEXT(a_dst_hold, dst_valid && !dst_ready, dst_valid)
    `CED_ASSERT_NEXT(a_dst_stable, dst_valid && !dst_ready, $stable(dst_word))

    // The end of a literal always closes the run of its final byte.
    `CED_ASSERT_IMPLY(a_done_last, dst_valid && dst_word.literal_done, dst_word.run_last)

    // A word with no byte carries a zero byte.
    `CED_ASSERT_IMPLY(a_empty_zero, dst_valid && !dst_word.byte_valid,
                      dst_word.out_byte == 8'd0)

    // A stray backslash is only reported at literal end and carries no byte.
    `CED_ASSERT_IMPLY(a_stray_end, dst_valid && dst_word.status == ST_STRAY,
                      !dst_word.byte_valid && dst_word.literal_done)

endmodule

bind c_escape_sequence_decoder ced_checker u_ced_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_word  (dst_word)
);

`default_nettype wire
